### rtl/bbr_pkg.sv
package bbr_pkg;

    // Space and free-map geometry
    localparam int ORDER_COUNT = 10;
    localparam int ORD_W       = 4;
    localparam int ADDR_W      = 10;
    localparam int IDX_W       = ADDR_W + 1;
    localparam int MAP_DEPTH   = 1 << IDX_W;
    localparam int TOP_ORDER_I = ((ORDER_COUNT - 1) > ADDR_W) ? ADDR_W : (ORDER_COUNT - 1);
    localparam logic [ORD_W-1:0] TOP_ORDER = ORD_W'(TOP_ORDER_I);

    // Word layouts
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    typedef enum logic {
        FUNC_MARK    = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STAT_DONE         = 2'd0,
        STAT_MISALIGNED   = 2'd1,
        STAT_ALREADY_FREE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OWN,
        ST_BUDDY,
        ST_SET,
        ST_FIN
    } state_t;

    // Bit position of the block of order ord at address addr
    function automatic logic [IDX_W-1:0] map_index(input logic [ORD_W-1:0]  ord,
                                                   input logic [ADDR_W-1:0] addr);
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] offs;
        base = IDX_W'(MAP_DEPTH / 2) >> ord;
        offs = {1'b0, addr} >> ord;
        return base + offs;
    endfunction

endpackage

### rtl/bbr_ram.sv
module bbr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/buddy_block_release_core.sv
// Paths: a bad order or address goes straight to the result word; a mark or an
// already-free block reads its own bit first; a release reads its own bit and then
// probes one buddy per order, with an extra set step when the top order is reached.
// One item at a time: the next word is taken in the cycle its result word can leave,
// so an item holds the block until its result word is registered; each order costs one free-map read.
// Reset: after aresetn is released, a clearing pass writes all 2048 free-map
// entries to zero, one per cycle; s_tready stays low until the pass is done.
module buddy_block_release_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] order, [13:4] address, [15:14] zero
    input  logic [bbr_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] func
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] final_order, [13:4] final_address, [17:14] merge_count,
    // [19:18] status, [23:20] zero
    output logic [bbr_pkg::M_DATA_W-1:0]   m_tdata
);

    bbr_pkg::state_t               state_reg, state_next;
    logic                          func_reg;
    logic [bbr_pkg::ORD_W-1:0]     ord_reg;
    logic [bbr_pkg::ADDR_W-1:0]    addr_reg;
    logic [bbr_pkg::ORD_W-1:0]     merge_reg;
    bbr_pkg::status_t              status_reg;
    logic [bbr_pkg::IDX_W-1:0]     clr_cnt_reg;
    logic                          m_tvalid_reg;
    logic [bbr_pkg::M_DATA_W-1:0]  m_tdata_reg;

    logic [bbr_pkg::ORD_W-1:0]     in_ord;
    logic [bbr_pkg::ADDR_W-1:0]    in_addr;
    logic [bbr_pkg::ADDR_W-1:0]    in_mask;
    logic                          in_bad;
    logic                          accept;
    logic [bbr_pkg::ADDR_W-1:0]    ord_bit;
    logic [bbr_pkg::ORD_W-1:0]     nord;
    logic [bbr_pkg::ADDR_W-1:0]    naddr;
    logic [bbr_pkg::ADDR_W-1:0]    nord_bit;
    logic                          out_free;

    logic                          mem_we;
    logic [bbr_pkg::IDX_W-1:0]     mem_waddr;
    logic                          mem_wdata;
    logic [bbr_pkg::IDX_W-1:0]     mem_raddr;
    logic                          mem_rdata;

    // Decode the incoming word and the merge step
    assign in_ord   = s_tdata[3:0];
    assign in_addr  = s_tdata[13:4];
    assign in_mask  = (bbr_pkg::ADDR_W'(1) << in_ord) - bbr_pkg::ADDR_W'(1);
    assign in_bad   = (in_ord > bbr_pkg::TOP_ORDER) || ((in_addr & in_mask) != '0);
    assign s_tready = (state_reg == bbr_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign ord_bit  = bbr_pkg::ADDR_W'(1) << ord_reg;
    assign nord     = ord_reg + bbr_pkg::ORD_W'(1);
    assign naddr    = addr_reg & ~ord_bit;
    assign nord_bit = bbr_pkg::ADDR_W'(1) << nord;
    assign out_free = !m_tvalid_reg || m_tready;

    bbr_ram #(
        .WIDTH (1),
        .DEPTH (bbr_pkg::MAP_DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bbr_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == bbr_pkg::IDX_W'(bbr_pkg::MAP_DEPTH - 1)) begin
                    state_next = bbr_pkg::ST_IDLE;
                end
            end
            bbr_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = in_bad ? bbr_pkg::ST_FIN : bbr_pkg::ST_OWN;
                end
            end
            bbr_pkg::ST_OWN: begin
                if (mem_rdata || func_reg == bbr_pkg::FUNC_MARK
                        || ord_reg == bbr_pkg::TOP_ORDER) begin
                    state_next = bbr_pkg::ST_FIN;
                end else begin
                    state_next = bbr_pkg::ST_BUDDY;
                end
            end
            bbr_pkg::ST_BUDDY: begin
                if (!mem_rdata) begin
                    state_next = bbr_pkg::ST_FIN;
                end else if (nord == bbr_pkg::TOP_ORDER) begin
                    state_next = bbr_pkg::ST_SET;
                end
            end
            bbr_pkg::ST_SET: begin
                state_next = bbr_pkg::ST_FIN;
            end
            bbr_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = bbr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bbr_pkg::ST_CLEAR;
            end
        endcase
    end

    // Free-map accesses
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = bbr_pkg::map_index(ord_reg, addr_reg);
        mem_wdata = 1'b1;
        mem_raddr = bbr_pkg::map_index(ord_reg, addr_reg ^ ord_bit);
        case (state_reg)
            bbr_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = 1'b0;
            end
            bbr_pkg::ST_IDLE: begin
                mem_raddr = bbr_pkg::map_index(in_ord, in_addr);
            end
            bbr_pkg::ST_OWN: begin
                // set the own bit when no merge can follow
                mem_we = !mem_rdata && (func_reg == bbr_pkg::FUNC_MARK
                                        || ord_reg == bbr_pkg::TOP_ORDER);
            end
            bbr_pkg::ST_BUDDY: begin
                // a free buddy is taken out, else the block is set
                mem_we    = 1'b1;
                mem_wdata = !mem_rdata;
                if (mem_rdata) begin
                    mem_waddr = bbr_pkg::map_index(ord_reg, addr_reg ^ ord_bit);
                end
                mem_raddr = bbr_pkg::map_index(nord, naddr ^ nord_bit);
            end
            bbr_pkg::ST_SET: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bbr_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == bbr_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + bbr_pkg::IDX_W'(1);
            end
            if (state_reg == bbr_pkg::ST_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working block and result word
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= s_tuser;
            ord_reg    <= in_ord;
            addr_reg   <= in_addr;
            merge_reg  <= '0;
            status_reg <= in_bad ? bbr_pkg::STAT_MISALIGNED : bbr_pkg::STAT_DONE;
        end
        if (state_reg == bbr_pkg::ST_OWN && mem_rdata) begin
            status_reg <= bbr_pkg::STAT_ALREADY_FREE;
        end
        if (state_reg == bbr_pkg::ST_BUDDY && mem_rdata) begin
            ord_reg   <= nord;
            addr_reg  <= naddr;
            merge_reg <= merge_reg + bbr_pkg::ORD_W'(1);
        end
        if (state_reg == bbr_pkg::ST_FIN && out_free) begin
            m_tdata_reg <= {4'b0000, status_reg, merge_reg, addr_reg, ord_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bbr_pkg::ST_IDLE |-> !mem_we)
        else $error("free map written while idle");

    a_merge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[17:14] <= bbr_pkg::TOP_ORDER)
        else $error("merge count above top order");

    a_error_no_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19:18] != bbr_pkg::STAT_DONE |-> m_tdata[17:14] == '0)
        else $error("merges reported on an error result");

    a_accept_path: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == bbr_pkg::ST_OWN || state_reg == bbr_pkg::ST_FIN)
        else $error("accepted word took an unexpected path");

endmodule
